// ===== src/tgarle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared widths, register indexes, reset values and the control/status
// structures that join the controller and the datapath.
// ----------------------------------------------------------------------------
package tgarle_pkg;

    localparam int BYTE_W      = 8;
    localparam int WORD_W      = 16;
    localparam int ADDR_W      = 20;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIM_REG_W   = 11;
    localparam int BURST_LIMIT = 64;
    localparam int BURST_W     = 7;
    localparam int COUNT_W     = 8;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH      = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_FOUR_BYTE_PIXELS = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FORMAT_4444      = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BOTTOM_UP        = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RUN_LENGTH_CODED = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_OPAQUE_FLAG_WORD = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_TRANSPARENT_WORD = 3'd7;

    // Register values after reset.
    localparam int                    RST_IMAGE_DIM        = 256;
    localparam logic                  RST_FOUR_BYTE_PIXELS = 1'b1;
    localparam logic                  RST_FORMAT_4444      = 1'b0;
    localparam logic                  RST_BOTTOM_UP        = 1'b1;
    localparam logic                  RST_RUN_LENGTH_CODED = 1'b1;
    localparam logic [WORD_W-1:0]     RST_OPAQUE_FLAG_WORD = 16'h8000;
    localparam logic [WORD_W-1:0]     RST_TRANSPARENT_WORD = 16'h07E0;

    // Packet header fields.
    localparam int HDR_RUN_BIT = 7;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic emit;
        logic last;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [BURST_W-1:0] burst_count;
        logic               image_complete;
        logic               last_pixel;
        logic               out_free;
        logic               restart;
    } dp_status_t;

endpackage

// ===== src/tgarle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE decoder controller
// Accepts stream words and sequences the pixel bursts that each word causes.
// ----------------------------------------------------------------------------
module tgarle_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tgarle_pkg::dp_status_t status,
    output tgarle_pkg::ctrl_cmd_t  cmd
);
    import tgarle_pkg::*;

    ctrl_state_t        state_reg, state_next;
    logic [BURST_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && (status.burst_count != '0) && !status.image_complete) begin
                    state_next = ST_EMIT;
                    cnt_next   = status.burst_count;
                end
            end
            ST_EMIT: begin
                // A burst ends on its final pixel or when the image fills up.
                cmd.last = (cnt_reg == BURST_W'(1)) || status.last_pixel;
                cmd.emit = status.out_free;
                if (status.out_free) begin
                    cnt_next = cnt_reg - BURST_W'(1);
                    if (cmd.last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
        endcase
        if (status.restart) begin
            state_next = ST_IDLE;
            cnt_next   = '0;
        end
    end

endmodule

// ===== src/tgarle_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE decoder datapath
// Configuration registers, packet parser, pixel gather and conversion,
// address counters and the output register.
// ----------------------------------------------------------------------------
module tgarle_datapath #(
    parameter int MAX_DIM = 1024
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [tgarle_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic [tgarle_pkg::BYTE_W-1:0]          s_data_byte,
    input  tgarle_pkg::ctrl_cmd_t                  cmd,
    output tgarle_pkg::dp_status_t                 status,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic [tgarle_pkg::WORD_W-1:0]          m_pixel_word,
    output logic [tgarle_pkg::ADDR_W-1:0]          m_pixel_address,
    output logic                                   m_last_of_run,
    output logic                                   m_image_done
);
    import tgarle_pkg::*;

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int CMP_W   = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
    localparam int RST_DIM = (RST_IMAGE_DIM > MAX_DIM) ? MAX_DIM : RST_IMAGE_DIM;
    localparam logic [ADDR_W-1:0] RST_BASE = ADDR_W'((RST_DIM - 1) * RST_DIM);
    localparam int PROD_W  = 2 * DIM_W;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
        logic [CMP_W-1:0] ve;
        ve = CMP_W'(v);
        if (v == '0) begin
            return DIM_W'(1);
        end
        if (ve > CMP_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(v);
    endfunction

    function automatic logic [WORD_W-1:0] convert_pixel(
        input logic [31:0]       p,
        input logic              fmt4444,
        input logic [WORD_W-1:0] opaque,
        input logic [WORD_W-1:0] transp
    );
        logic [7:0] b, g, r, a;
        b = p[7:0];
        g = p[15:8];
        r = p[23:16];
        a = p[31:24];
        if (fmt4444) begin
            return {a[7:4], r[7:4], g[7:4], b[7:4]};
        end
        if (a == 8'd0) begin
            return transp;
        end
        return opaque | {1'b0, r[7:3], g[7:3], b[7:3]};
    endfunction

    // Configuration registers.
    logic [DIM_REG_W-1:0] width_reg, width_next;
    logic [DIM_REG_W-1:0] height_reg, height_next;
    logic                 four_reg, four_next;
    logic                 fmt4444_reg, fmt4444_next;
    logic                 bottom_up_reg, bottom_up_next;
    logic                 rlc_reg, rlc_next;
    logic [WORD_W-1:0]    opaque_reg, opaque_next;
    logic [WORD_W-1:0]    transp_reg, transp_next;

    // Parser and position state.
    logic                 exp_reg, exp_next;
    logic                 run_reg, run_next;
    logic [COUNT_W-1:0]   left_reg, left_next;
    logic [1:0]           bip_reg, bip_next;
    logic [31:0]          gather_reg, gather_next;
    logic [WORD_W-1:0]    emit_word_reg, emit_word_next;
    logic [DIM_W-1:0]     col_reg, row_reg;
    logic [ADDR_W-1:0]    base_reg;

    // Output register.
    logic                 m_valid_reg;
    logic [WORD_W-1:0]    m_word_reg;
    logic [ADDR_W-1:0]    m_addr_reg;
    logic                 m_last_reg;
    logic                 m_done_reg;

    logic [DIM_W-1:0]     w_dim, h_dim, w_new, h_new;
    logic [PROD_W-1:0]    base_prod;
    logic [ADDR_W-1:0]    base_restart;
    logic [BURST_W-1:0]   burst;
    logic [31:0]          g_new, g_full;
    logic [1:0]           bip1;
    logic [2:0]           need;
    logic                 complete;
    logic [BURST_W-1:0]   first;
    logic [DIM_W-1:0]     col1, row1;
    logic                 col_wrap;

    // Register writes.
    always_comb begin
        width_next     = width_reg;
        height_next    = height_reg;
        four_next      = four_reg;
        fmt4444_next   = fmt4444_reg;
        bottom_up_next = bottom_up_reg;
        rlc_next       = rlc_reg;
        opaque_next    = opaque_reg;
        transp_next    = transp_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH:      width_next     = cfg_wdata[DIM_REG_W-1:0];
                REG_IMAGE_HEIGHT:     height_next    = cfg_wdata[DIM_REG_W-1:0];
                REG_FOUR_BYTE_PIXELS: four_next      = cfg_wdata[0];
                REG_FORMAT_4444:      fmt4444_next   = cfg_wdata[0];
                REG_BOTTOM_UP:        bottom_up_next = cfg_wdata[0];
                REG_RUN_LENGTH_CODED: rlc_next       = cfg_wdata[0];
                REG_OPAQUE_FLAG_WORD: opaque_next    = cfg_wdata;
                REG_TRANSPARENT_WORD: transp_next    = cfg_wdata;
            endcase
        end
    end

    assign w_dim        = clamp_dim(width_reg);
    assign h_dim        = clamp_dim(height_reg);
    assign w_new        = clamp_dim(width_next);
    assign h_new        = clamp_dim(height_next);
    assign base_prod    = (h_new - DIM_W'(1)) * w_new;
    assign base_restart = bottom_up_next ? ADDR_W'(base_prod) : '0;

    // Packet parser and pixel gather for the offered byte.
    always_comb begin
        g_new    = gather_reg | (32'(s_data_byte) << {bip_reg, 3'b000});
        bip1     = bip_reg + 2'd1;
        need     = four_reg ? 3'd4 : 3'd3;
        complete = ({1'b0, bip1} >= need) || (bip1 == 2'd0);
        g_full   = four_reg ? g_new : (g_new | 32'hFF00_0000);
        first    = (left_reg > COUNT_W'(BURST_LIMIT)) ? BURST_W'(BURST_LIMIT)
                                                        : left_reg[BURST_W-1:0];

        exp_next       = exp_reg;
        run_next       = run_reg;
        left_next      = left_reg;
        bip_next       = bip_reg;
        gather_next    = gather_reg;
        emit_word_next = emit_word_reg;
        burst          = '0;

        if (rlc_reg && exp_reg) begin
            // Header byte: flush what is left of a long run first.
            if (run_reg && (left_reg != '0)) begin
                burst = first;
            end
            emit_word_next = convert_pixel(gather_reg, fmt4444_reg, opaque_reg, transp_reg);
            run_next       = s_data_byte[HDR_RUN_BIT];
            left_next      = {1'b0, s_data_byte[HDR_RUN_BIT-1:0]} + COUNT_W'(1);
            exp_next       = 1'b0;
            bip_next       = '0;
            gather_next    = '0;
        end else if (!complete) begin
            gather_next = g_new;
            bip_next    = bip1;
        end else begin
            bip_next       = '0;
            emit_word_next = convert_pixel(g_full, fmt4444_reg, opaque_reg, transp_reg);
            if (!rlc_reg) begin
                burst = BURST_W'(1);
            end else if (run_reg) begin
                burst     = first;
                left_next = left_reg - COUNT_W'(first);
                exp_next  = 1'b1;
            end else begin
                burst = BURST_W'(1);
                if (left_reg != '0) begin
                    left_next = left_reg - COUNT_W'(1);
                end
                if (left_next == '0) begin
                    exp_next = 1'b1;
                end
            end
            // A run longer than one burst keeps its pixel for the next header.
            if (rlc_reg && run_reg && exp_next && (left_next != '0)) begin
                gather_next = g_full;
            end else begin
                gather_next = '0;
            end
        end
    end

    assign col1     = col_reg + DIM_W'(1);
    assign row1     = row_reg + DIM_W'(1);
    assign col_wrap = (col1 >= w_dim);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= DIM_REG_W'(RST_IMAGE_DIM);
            height_reg    <= DIM_REG_W'(RST_IMAGE_DIM);
            four_reg      <= RST_FOUR_BYTE_PIXELS;
            fmt4444_reg   <= RST_FORMAT_4444;
            bottom_up_reg <= RST_BOTTOM_UP;
            rlc_reg       <= RST_RUN_LENGTH_CODED;
            opaque_reg    <= RST_OPAQUE_FLAG_WORD;
            transp_reg    <= RST_TRANSPARENT_WORD;
            exp_reg       <= RST_RUN_LENGTH_CODED;
            run_reg       <= 1'b0;
            left_reg      <= '0;
            bip_reg       <= '0;
            gather_reg    <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            base_reg      <= RST_BOTTOM_UP ? RST_BASE : '0;
            m_valid_reg   <= 1'b0;
        end else begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            four_reg      <= four_next;
            fmt4444_reg   <= fmt4444_next;
            bottom_up_reg <= bottom_up_next;
            rlc_reg       <= rlc_next;
            opaque_reg    <= opaque_next;
            transp_reg    <= transp_next;

            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_wr_en) begin
                exp_reg    <= rlc_next;
                run_reg    <= 1'b0;
                left_reg   <= '0;
                bip_reg    <= '0;
                gather_reg <= '0;
                col_reg    <= '0;
                row_reg    <= '0;
                base_reg   <= base_restart;
            end else begin
                if (cmd.accept) begin
                    exp_reg    <= exp_next;
                    run_reg    <= run_next;
                    left_reg   <= left_next;
                    bip_reg    <= bip_next;
                    gather_reg <= gather_next;
                end
                if (cmd.emit) begin
                    if (col_wrap) begin
                        col_reg <= '0;
                        row_reg <= row1;
                        if (row1 < h_dim) begin
                            base_reg <= bottom_up_reg ? (base_reg - ADDR_W'(w_dim))
                                                      : (base_reg + ADDR_W'(w_dim));
                        end
                    end else begin
                        col_reg <= col1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            emit_word_reg <= emit_word_next;
        end
        if (cmd.emit) begin
            m_word_reg <= emit_word_reg;
            m_addr_reg <= base_reg + ADDR_W'(col_reg);
            m_last_reg <= cmd.last;
            m_done_reg <= col_wrap && (row1 >= h_dim);
        end
    end

    assign status.burst_count    = burst;
    assign status.image_complete = (row_reg >= h_dim);
    assign status.last_pixel     = col_wrap && (row1 >= h_dim);
    assign status.out_free       = !m_valid_reg || m_ready;
    assign status.restart        = cfg_wr_en;

    assign m_valid         = m_valid_reg;
    assign m_pixel_word    = m_word_reg;
    assign m_pixel_address = m_addr_reg;
    assign m_last_of_run   = m_last_reg;
    assign m_image_done    = m_done_reg;

endmodule

// ===== src/tga_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes the pixel stream of a TGA image into 16-bit pixels with addresses.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries the image data one byte per word. The header is
// parsed by software and written through the cfg_ port (index, 16-bit data,
// write enable); every write restarts decoding of the image. Writes must
// only happen while the block is idle.
// The m_ channel returns one word per decoded pixel: the 4444 or 1555 value,
// its address (rows mirrored when bottom_up is set), a flag on the last pixel
// produced by one input byte, and a flag on the final pixel of the image.
// Timing: an input byte is taken while the controller is idle. A byte that completes a pixel
// or flushes a long run then emits its pixels one per cycle while the receiver takes
// them, up to 64; the controller first moves to its emit state, then the output
// register is loaded with the first one. No new byte is taken until the burst is done.
// The single output register paces the burst.
// If the receiver stalls, the burst holds and s_ready stays low until it is
// done. Reset loads the default registers (256x256, BGRA, 1555, bottom-up,
// run-length coded) and clears the image position.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
    parameter int MAX_DIM = 1024
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [tgarle_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [tgarle_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [tgarle_pkg::BYTE_W-1:0]     s_data_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [tgarle_pkg::WORD_W-1:0]     m_pixel_word,
    output logic [tgarle_pkg::ADDR_W-1:0]     m_pixel_address,
    output logic                              m_last_of_run,
    output logic                              m_image_done
);
    import tgarle_pkg::*;

    // Commands from the controller and status back from the datapath.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The controller owns the input handshake and counts out each burst.
    tgarle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath parses packets, converts pixels, tracks the image
    // position and holds the output register.
    tgarle_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_data_byte     (s_data_byte),
        .cmd             (cmd),
        .status          (status),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_word    (m_pixel_word),
        .m_pixel_address (m_pixel_address),
        .m_last_of_run   (m_last_of_run),
        .m_image_done    (m_image_done)
    );

endmodule
